/* rtl/si_pkg.sv */
// shared constants for the segment intersection block
// meet kind codes, field widths and default parameter values; no dependencies

package si_pkg;

  localparam int COORD_BITS_DEF = 16;
  localparam int FRAC_BITS_DEF  = 16;
  localparam int FIELD_BITS     = 16;
  localparam int NUM_COORDS     = 8;
  localparam int OUT_BITS       = 32;
  localparam int QUEUE_DEPTH    = 4;

  typedef logic [1:0] kind_t;

  localparam kind_t KIND_NONE    = 2'd0;
  localparam kind_t KIND_POINT   = 2'd1;
  localparam kind_t KIND_OVERLAP = 2'd2;

endpackage

/* rtl/si_front.sv */
// front pipeline: coordinate capture, cross products, classification and the
// numerator products for the crossing point; uses si_pkg

module si_front #(
  parameter int COORD_BITS = si_pkg::COORD_BITS_DEF,
  parameter int FRAC_BITS  = si_pkg::FRAC_BITS_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  logic [si_pkg::NUM_COORDS*si_pkg::FIELD_BITS-1:0] in_data,
  output logic item_valid,
  input  logic item_ready,
  output logic [4+2*COORD_BITS+(2*COORD_BITS+1)+2*(3*COORD_BITS+1)-1:0] item_data
);
  import si_pkg::*;

  localparam int C  = COORD_BITS;
  localparam int EW = (C > FIELD_BITS) ? C : FIELD_BITS;
  localparam int DF = C + 1;
  localparam int PW = 2 * C + 2;
  localparam int XW = 2 * C + 3;
  localparam int DW = 2 * C + 1;
  localparam int MW = 3 * C + 1;

  logic en;

  // stage 0: coordinates cut from the input fields, zero-extended if wider
  logic                v0_r;
  logic signed [C-1:0] c_r   [NUM_COORDS];
  logic signed [C-1:0] c_nxt [NUM_COORDS];

  // stage 1: edge vectors and bounding box test
  logic                 v1_r;
  logic signed [DF-1:0] rx_r, ry_r, sx_r, sy_r, qx_r, qy_r;
  logic                 ovl1_r;
  logic signed [C-1:0]  bx1_r, by1_r;
  logic                 ovl1_nxt;

  // stage 2: partial products
  logic                 v2_r;
  logic signed [PW-1:0] p_r [6];
  logic                 ovl2_r;
  logic signed [C-1:0]  bx2_r, by2_r;
  logic signed [DF-1:0] rx2_r, ry2_r;

  // stage 3: determinant and parameter numerators
  logic                 v3_r;
  logic signed [XW-1:0] den3_r, tn3_r, un3_r;
  logic                 ovl3_r;
  logic signed [C-1:0]  bx3_r, by3_r;
  logic signed [DF-1:0] rx3_r, ry3_r;

  // stage 4: classified
  logic                 v4_r;
  kind_t                kind4_r, kind4_nxt;
  logic [DW-1:0]        den4_r, tn4_r;
  logic [C-1:0]         magx4_r, magy4_r;
  logic                 negx4_r, negy4_r;
  logic signed [C-1:0]  bx4_r, by4_r;
  logic signed [XW-1:0] dn, tnn, unn;

  // stage 5: the t numerator scaled by the magnitudes of the edge components
  logic                v5_r;
  kind_t               kind5_r;
  logic [DW-1:0]       den5_r;
  logic [MW-1:0]       px5_r, py5_r;
  logic                negx5_r, negy5_r;
  logic signed [C-1:0] bx5_r, by5_r;

  function automatic logic rng(input logic signed [C-1:0] p, input logic signed [C-1:0] a,
                               input logic signed [C-1:0] b);
    return ((p >= a) && (p <= b)) || ((p >= b) && (p <= a));
  endfunction

  function automatic logic in_both(input logic signed [C-1:0] px, input logic signed [C-1:0] py,
                                   input logic signed [C-1:0] c [NUM_COORDS]);
    return rng(px, c[0], c[2]) && rng(py, c[1], c[3]) &&
           rng(px, c[4], c[6]) && rng(py, c[5], c[7]);
  endfunction

  assign en       = !v5_r || item_ready;
  assign in_ready = en;

  always_comb begin
    logic [EW-1:0] ext;
    for (int i = 0; i < NUM_COORDS; i++) begin
      ext      = EW'(in_data[i*FIELD_BITS +: FIELD_BITS]);
      c_nxt[i] = ext[C-1:0];
    end
  end

  assign ovl1_nxt = in_both(c_r[0], c_r[1], c_r) || in_both(c_r[2], c_r[3], c_r) ||
                    in_both(c_r[4], c_r[5], c_r) || in_both(c_r[6], c_r[7], c_r);

  always_comb begin
    logic dz, neg;
    dz  = (den3_r == '0);
    neg = den3_r[XW-1];
    dn  = neg ? -den3_r : den3_r;
    tnn = neg ? -tn3_r : tn3_r;
    unn = neg ? -un3_r : un3_r;
    if (dz) begin
      kind4_nxt = (tn3_r == '0 && un3_r == '0 && ovl3_r) ? KIND_OVERLAP : KIND_NONE;
    end else if (!tnn[XW-1] && tnn <= dn && !unn[XW-1] && unn <= dn) begin
      kind4_nxt = KIND_POINT;
    end else begin
      kind4_nxt = KIND_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else if (en) begin
      v0_r <= in_valid;
      v1_r <= v0_r;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c_r <= c_nxt;

      rx_r   <= DF'(c_r[2]) - DF'(c_r[0]);
      ry_r   <= DF'(c_r[3]) - DF'(c_r[1]);
      sx_r   <= DF'(c_r[6]) - DF'(c_r[4]);
      sy_r   <= DF'(c_r[7]) - DF'(c_r[5]);
      qx_r   <= DF'(c_r[4]) - DF'(c_r[0]);
      qy_r   <= DF'(c_r[5]) - DF'(c_r[1]);
      ovl1_r <= ovl1_nxt;
      bx1_r  <= c_r[0];
      by1_r  <= c_r[1];

      p_r[0] <= PW'(rx_r) * PW'(sy_r);
      p_r[1] <= PW'(ry_r) * PW'(sx_r);
      p_r[2] <= PW'(qx_r) * PW'(sy_r);
      p_r[3] <= PW'(qy_r) * PW'(sx_r);
      p_r[4] <= PW'(qx_r) * PW'(ry_r);
      p_r[5] <= PW'(qy_r) * PW'(rx_r);
      ovl2_r <= ovl1_r;
      bx2_r  <= bx1_r;
      by2_r  <= by1_r;
      rx2_r  <= rx_r;
      ry2_r  <= ry_r;

      den3_r <= XW'(p_r[0]) - XW'(p_r[1]);
      tn3_r  <= XW'(p_r[2]) - XW'(p_r[3]);
      un3_r  <= XW'(p_r[4]) - XW'(p_r[5]);
      ovl3_r <= ovl2_r;
      bx3_r  <= bx2_r;
      by3_r  <= by2_r;
      rx3_r  <= rx2_r;
      ry3_r  <= ry2_r;

      kind4_r <= kind4_nxt;
      den4_r  <= dn[DW-1:0];
      tn4_r   <= tnn[DW-1:0];
      magx4_r <= rx3_r[DF-1] ? C'(-rx3_r) : C'(rx3_r);
      magy4_r <= ry3_r[DF-1] ? C'(-ry3_r) : C'(ry3_r);
      negx4_r <= rx3_r[DF-1];
      negy4_r <= ry3_r[DF-1];
      bx4_r   <= bx3_r;
      by4_r   <= by3_r;

      kind5_r <= kind4_r;
      den5_r  <= den4_r;
      px5_r   <= MW'(tn4_r) * MW'(magx4_r);
      py5_r   <= MW'(tn4_r) * MW'(magy4_r);
      negx5_r <= negx4_r;
      negy5_r <= negy4_r;
      bx5_r   <= bx4_r;
      by5_r   <= by4_r;
    end
  end

  assign item_valid = v5_r;
  assign item_data  = {px5_r, py5_r, den5_r, negy5_r, negx5_r, by5_r, bx5_r, kind5_r};

endmodule

/* rtl/si_queue.sv */
// short queue between the front and back pipelines
// register array with read and write pointers; uses si_pkg

module si_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push_valid,
  output logic             push_ready,
  input  logic [WIDTH-1:0] push_data,
  output logic             pop_valid,
  input  logic             pop_ready,
  output logic [WIDTH-1:0] pop_data
);
  import si_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [AW-1:0]    wr_ptr_r, rd_ptr_r;
  logic [CW-1:0]    count_r;
  logic             push, pop;

  assign push_ready = (count_r != CW'(DEPTH));
  assign pop_valid  = (count_r != '0);
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_data   = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

/* rtl/si_back.sv */
// back pipeline: restoring division, one quotient bit per stage, for both
// coordinates, then truncation toward zero and the output register; uses si_pkg

module si_back #(
  parameter int COORD_BITS = si_pkg::COORD_BITS_DEF,
  parameter int FRAC_BITS  = si_pkg::FRAC_BITS_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  logic item_valid,
  output logic item_ready,
  input  logic [4+2*COORD_BITS+(2*COORD_BITS+1)+2*(3*COORD_BITS+1)-1:0] item_data,
  output logic out_valid,
  input  logic out_ready,
  output si_pkg::kind_t out_kind,
  output logic [si_pkg::OUT_BITS-1:0] out_x,
  output logic [si_pkg::OUT_BITS-1:0] out_y
);
  import si_pkg::*;

  localparam int C  = COORD_BITS;
  localparam int DW = 2 * C + 1;
  localparam int MW = 3 * C + 1;
  localparam int QB = C + FRAC_BITS;
  localparam int NW = MW + FRAC_BITS;
  localparam int WW = (C + FRAC_BITS + 2 > OUT_BITS) ? C + FRAC_BITS + 2 : OUT_BITS + 1;

  typedef struct packed {
    logic                v;
    kind_t               kind;
    logic signed [C-1:0] bx;
    logic signed [C-1:0] by;
    logic                negx;
    logic                negy;
    logic [DW-1:0]       den;
    logic [DW-1:0]       prx;
    logic [DW-1:0]       pry;
    logic [QB-1:0]       lox;
    logic [QB-1:0]       loy;
    logic [QB-1:0]       qx;
    logic [QB-1:0]       qy;
  } dstage_t;

  dstage_t st_r   [QB+1];
  dstage_t st_nxt [QB+1];

  logic                en;
  logic [NW-1:0]       nx, ny;
  logic                out_v_r;
  kind_t               kind_r;
  logic [OUT_BITS-1:0] x_r, y_r;

  function automatic logic [OUT_BITS-1:0] finish(input logic signed [C-1:0] base,
                                                 input logic neg, input logic [QB-1:0] q,
                                                 input logic rem_nz);
    logic signed [WW-1:0] a, w;
    a = WW'(base) <<< FRAC_BITS;
    if (neg) begin
      w = a - $signed(WW'(q));
      if (rem_nz && w >= 1) w = w - 1;
    end else begin
      w = a + $signed(WW'(q));
      if (rem_nz && w < 0) w = w + 1;
    end
    return w[OUT_BITS-1:0];
  endfunction

  assign en         = !out_v_r || out_ready;
  assign item_ready = en;

  assign nx = NW'(item_data[4+2*C+DW+MW +: MW]) << FRAC_BITS;
  assign ny = NW'(item_data[4+2*C+DW +: MW]) << FRAC_BITS;

  always_comb begin
    logic [DW:0] tx, ty;
    logic        gx, gy;
    st_nxt[0].v    = item_valid;
    st_nxt[0].kind = item_data[1:0];
    st_nxt[0].bx   = item_data[2 +: C];
    st_nxt[0].by   = item_data[2+C +: C];
    st_nxt[0].negx = item_data[2+2*C];
    st_nxt[0].negy = item_data[3+2*C];
    st_nxt[0].den  = item_data[4+2*C +: DW];
    // the quotient fits in QB bits, so the top of the numerator is below den
    st_nxt[0].prx  = nx[NW-1:QB];
    st_nxt[0].pry  = ny[NW-1:QB];
    st_nxt[0].lox  = nx[QB-1:0];
    st_nxt[0].loy  = ny[QB-1:0];
    st_nxt[0].qx   = '0;
    st_nxt[0].qy   = '0;
    for (int j = 0; j < QB; j++) begin
      tx = {st_r[j].prx, st_r[j].lox[QB-1]};
      ty = {st_r[j].pry, st_r[j].loy[QB-1]};
      gx = (tx >= {1'b0, st_r[j].den});
      gy = (ty >= {1'b0, st_r[j].den});
      st_nxt[j+1]     = st_r[j];
      st_nxt[j+1].prx = gx ? DW'(tx - {1'b0, st_r[j].den}) : DW'(tx);
      st_nxt[j+1].pry = gy ? DW'(ty - {1'b0, st_r[j].den}) : DW'(ty);
      st_nxt[j+1].lox = st_r[j].lox << 1;
      st_nxt[j+1].loy = st_r[j].loy << 1;
      st_nxt[j+1].qx  = {st_r[j].qx[QB-2:0], gx};
      st_nxt[j+1].qy  = {st_r[j].qy[QB-2:0], gy};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int j = 0; j <= QB; j++) begin
        st_r[j].v <= 1'b0;
      end
      out_v_r <= 1'b0;
    end else if (en) begin
      st_r    <= st_nxt;
      out_v_r <= st_r[QB].v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      kind_r <= st_r[QB].kind;
      if (st_r[QB].kind == KIND_POINT) begin
        x_r <= finish(st_r[QB].bx, st_r[QB].negx, st_r[QB].qx, st_r[QB].prx != '0);
        y_r <= finish(st_r[QB].by, st_r[QB].negy, st_r[QB].qy, st_r[QB].pry != '0);
      end else begin
        x_r <= '0;
        y_r <= '0;
      end
    end
  end

  assign out_valid = out_v_r;
  assign out_kind  = kind_r;
  assign out_x     = x_r;
  assign out_y     = y_r;

  a_zero_unless_point: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && kind_r != KIND_POINT |-> x_r == '0 && y_r == '0)
    else $error("crossing point not cleared for a non-point result");

  a_entry_loaded: assert property (@(posedge clk) disable iff (!rst_n)
    en && item_valid |=> st_r[0].v)
    else $error("queued item not taken into the divider");

  a_remainder_bound: assert property (@(posedge clk) disable iff (!rst_n)
    st_r[QB].v && st_r[QB].kind == KIND_POINT |->
      st_r[QB].prx < st_r[QB].den && st_r[QB].pry < st_r[QB].den)
    else $error("divider remainder not below the determinant");

endmodule

/* rtl/segment_intersection.sv */
// top level of the two-segment intersection block
// wires the front pipeline, the queue and the divider back end; uses si_pkg

// Takes one pair of segments per cycle on the in_ stream while in_tready
// is high and returns one result per pair on the out_ stream, in order.
// The result kind (none, single crossing point, collinear overlap) is
// decided exactly from integer cross products; for a crossing the point is
// given in fixed point with FRAC_BITS fraction bits, truncated toward zero,
// and is zero otherwise. Throughput is one pair per clock once the pipeline
// is full and out_tready stays high. The back end is a restoring divider
// that resolves one quotient bit per stage for both coordinates at once. A
// four-entry queue separates the classification pipeline from the divider
// so each side can stall alone.

module segment_intersection #(
  parameter int COORD_BITS = si_pkg::COORD_BITS_DEF,
  parameter int FRAC_BITS  = si_pkg::FRAC_BITS_DEF
) (
  input  logic                                       clk,
  input  logic                                       rst_n,
  input  logic                                       in_tvalid,
  output logic                                       in_tready,
  // a_start_x, a_start_y, a_end_x, a_end_y, b_start_x, b_start_y, b_end_x, b_end_y
  input  logic [si_pkg::NUM_COORDS*si_pkg::FIELD_BITS-1:0] in_tdata,
  output logic                                       out_tvalid,
  input  logic                                       out_tready,
  // cross_x, cross_y
  output logic [2*si_pkg::OUT_BITS-1:0]              out_tdata,
  // meet_kind
  output logic [1:0]                                 out_tuser
);
  import si_pkg::*;

  localparam int C  = COORD_BITS;
  localparam int IW = 4 + 2*C + (2*C + 1) + 2*(3*C + 1);

  logic          f_valid, f_ready;
  logic [IW-1:0] f_data;
  logic          b_valid, b_ready;
  logic [IW-1:0] b_data;
  kind_t         kind;
  logic [OUT_BITS-1:0] x, y;

  si_front #(
    .COORD_BITS (COORD_BITS),
    .FRAC_BITS  (FRAC_BITS)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .in_data    (in_tdata),
    .item_valid (f_valid),
    .item_ready (f_ready),
    .item_data  (f_data)
  );

  si_queue #(
    .WIDTH (IW),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_data  (f_data),
    .pop_valid  (b_valid),
    .pop_ready  (b_ready),
    .pop_data   (b_data)
  );

  si_back #(
    .COORD_BITS (COORD_BITS),
    .FRAC_BITS  (FRAC_BITS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (b_valid),
    .item_ready (b_ready),
    .item_data  (b_data),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_kind   (kind),
    .out_x      (x),
    .out_y      (y)
  );

  assign out_tdata = {y, x};
  assign out_tuser = kind;

endmodule

/* sim/tb_segment_intersection.sv */
// testbench for segment_intersection: directed and random segment pairs
// checked against an exact integer predictor; depends on si_pkg and the rtl

module tb_segment_intersection;
  import si_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CB = COORD_BITS_DEF;
  localparam int FB = FRAC_BITS_DEF;
  localparam int LATENCY = CB + FB + 9;
  localparam longint CYCLE_LIMIT = 400000;

  typedef struct packed {
    kind_t kind;
    logic [31:0] cx;
    logic [31:0] cy;
  } meet_t;

  logic clk, rst_n;
  logic in_tvalid, in_tready, out_tvalid, out_tready;
  logic [NUM_COORDS*FIELD_BITS-1:0] in_tdata;
  logic [2*OUT_BITS-1:0] out_tdata;
  logic [1:0] out_tuser;

  segment_intersection uut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tuser(out_tuser)
  );

  logic [NUM_COORDS*FIELD_BITS-1:0] pair_queue[$];
  meet_t meet_queue[$];
  int errors = 0, n_point = 0, n_overlap = 0, n_none = 0, n_words = 0;
  int send_idle = 0, recv_idle = 0;
  int hold_off = 0;
  bit in_acc = 0;
  longint cycles = 0;

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  function automatic longint coord(logic [15:0] f);
    logic signed [CB-1:0] v;
    v = f[CB-1:0];
    return longint'(v);
  endfunction

  function automatic logic in_box(longint px, longint py, longint x1, longint y1,
                                  longint x2, longint y2);
    longint lx, hx, ly, hy;
    lx = x1 < x2 ? x1 : x2; hx = x1 < x2 ? x2 : x1;
    ly = y1 < y2 ? y1 : y2; hy = y1 < y2 ? y2 : y1;
    return px >= lx && px <= hx && py >= ly && py <= hy;
  endfunction

  // base + tn*dd/den in fixed point, truncated toward zero
  function automatic logic [31:0] fix_point(longint base, longint tn, longint den,
                                            longint dd);
    logic signed [127:0] num, whole, q;
    num = (128'(signed'(tn)) * 128'(signed'(dd))) <<< FB;
    whole = (128'(signed'(base)) <<< FB) * 128'(signed'(den)) + num;
    q = whole / 128'(signed'(den));  // sv division truncates toward zero
    return q[31:0];
  endfunction

  function automatic meet_t predict_meet(logic [NUM_COORDS*FIELD_BITS-1:0] d);
    longint c[8];
    longint rx, ry, sx, sy, qx, qy, den, tn, un;
    meet_t m;
    logic hit;
    for (int i = 0; i < 8; i++) c[i] = coord(d[i*16 +: 16]);
    rx = c[2]-c[0]; ry = c[3]-c[1]; sx = c[6]-c[4]; sy = c[7]-c[5];
    qx = c[4]-c[0]; qy = c[5]-c[1];
    den = rx*sy - ry*sx; tn = qx*sy - qy*sx; un = qx*ry - qy*rx;
    m = '{KIND_NONE, 32'd0, 32'd0};
    if (den == 0) begin
      hit = 0;
      for (int e = 0; e < 4; e++)
        if (in_box(c[2*e], c[2*e+1], c[0], c[1], c[2], c[3]) &&
            in_box(c[2*e], c[2*e+1], c[4], c[5], c[6], c[7])) hit = 1;
      if (tn == 0 && un == 0 && hit) m.kind = KIND_OVERLAP;
    end else begin
      if (den < 0) begin
        den = -den; tn = -tn; un = -un;
      end
      if (tn >= 0 && tn <= den && un >= 0 && un <= den) begin
        m.kind = KIND_POINT;
        m.cx = fix_point(c[0], tn, den, rx);
        m.cy = fix_point(c[1], tn, den, ry);
      end
    end
    return m;
  endfunction

  function automatic logic [15:0] rnd_coord(int span);
    if (span == 0) return 16'($urandom);
    return 16'($urandom_range(0, 2*span) - span);
  endfunction

  task automatic add_pair(logic [15:0] v[8]);
    logic [NUM_COORDS*FIELD_BITS-1:0] d;
    for (int i = 0; i < 8; i++) d[i*16 +: 16] = v[i];
    pair_queue.push_back(d);
  endtask

  // random pair, biased toward crossings, shared lines and touching ends
  task automatic add_random;
    logic [15:0] v[8];
    int span, mode, k;
    span = ($urandom_range(0, 3) == 0) ? 0 : ($urandom_range(0, 1) ? 20 : 3000);
    for (int i = 0; i < 8; i++) v[i] = rnd_coord(span);
    mode = $urandom_range(0, 9);
    if (mode < 2) begin
      // B on the line of A: multiples of a small direction
      k = $urandom_range(0, 1) ? 1 : 2;
      v[2] = v[0] + 16'(4*k); v[3] = v[1] + 16'(3*k);
      v[4] = v[0] + 16'(4*($urandom_range(0, 6) - 3));
      v[5] = v[1] + 16'(3*($urandom_range(0, 6) - 3)) ;
      v[5] = v[1] + 16'((signed'(v[4]) - signed'(v[0])) / 4 * 3);
      v[6] = v[4] + 16'(4*($urandom_range(0, 4) - 2));
      v[7] = v[5] + 16'((signed'(v[6]) - signed'(v[4])) / 4 * 3);
    end else if (mode == 2) begin
      v[4] = v[2]; v[5] = v[3];
    end else if (mode == 3) begin
      v[2] = v[0]; v[3] = v[1];
    end else if (mode < 7) begin
      // opposite corners so the segments tend to cross
      v[4] = v[0]; v[6] = v[2];
      v[5] = v[3]; v[7] = v[1];
      v[4] = v[4] + 16'($urandom_range(0, 6) - 3);
    end
    add_pair(v);
  endtask

  task automatic wait_drained;
    while (pair_queue.size() != 0 || meet_queue.size() != 0) @(posedge clk);
  endtask

  // driver
  always @(negedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 0;
    end else begin
      if (in_acc) pair_queue.pop_front();
      if ((in_tvalid && !in_acc) ||
          (pair_queue.size() > 0 && $urandom_range(0, 99) >= send_idle)) begin
        in_tvalid <= 1;
        in_tdata <= pair_queue[0];
      end else begin
        in_tvalid <= 0;
      end
      if (hold_off > 0) begin
        hold_off <= hold_off - 1;
        out_tready <= 0;
      end else begin
        out_tready <= ($urandom_range(0, 99) >= recv_idle);
      end
    end
  end

  // accepted pairs go to the predictor at the edge they are taken
  always @(posedge clk) begin
    in_acc <= rst_n && in_tvalid && in_tready;
    if (rst_n && in_tvalid && in_tready) meet_queue.push_back(predict_meet(in_tdata));
  end

  // monitor
  always @(posedge clk) begin
    meet_t got, want;
    cycles <= cycles + 1;
    if (rst_n && out_tvalid && out_tready) begin
      got = '{out_tuser, out_tdata[31:0], out_tdata[63:32]};
      n_words++;
      if (meet_queue.size() == 0) begin
        errors++;
        $display("%0t: unexpected word kind=%0d x=%h y=%h", $time, got.kind, got.cx,
                 got.cy);
      end else begin
        want = meet_queue.pop_front();
        case (want.kind)
          KIND_POINT: n_point++;
          KIND_OVERLAP: n_overlap++;
          default: n_none++;
        endcase
        if (got.kind !== want.kind) begin
          errors++;
          $display("%0t: kind expected %0d actual %0d", $time, want.kind, got.kind);
        end
        if (got.cx !== want.cx) begin
          errors++;
          $display("%0t: cross_x expected %h actual %h", $time, want.cx, got.cx);
        end
        if (got.cy !== want.cy) begin
          errors++;
          $display("%0t: cross_y expected %h actual %h", $time, want.cy, got.cy);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("tb_segment_intersection: errors");
      $finish;
    end
  end

  initial begin
    logic [15:0] v[8];
    rst_n = 0; in_tvalid = 0; in_tdata = '0; out_tready = 0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1;

    // directed: extremes, plain crossing, touching ends, parallel, collinear,
    // disjoint collinear, point segments, ignored upper bits n/a at 16 bits
    v = '{16'h8000, 16'h8000, 16'h7fff, 16'h7fff, 16'h8000, 16'h7fff, 16'h7fff, 16'h8000};
    add_pair(v);
    v = '{16'h7fff, 16'h8000, 16'h8000, 16'h7fff, 16'h8000, 16'h8000, 16'h7fff, 16'h7fff};
    add_pair(v);
    v = '{0, 0, 10, 10, 0, 10, 10, 0};  add_pair(v);
    v = '{0, 0, 3, 1, 0, 1, 1, 0};      add_pair(v);
    v = '{0, 0, 10, 0, 10, 0, 10, 5};   add_pair(v);
    v = '{0, 0, 10, 0, 0, 1, 10, 1};    add_pair(v);
    v = '{0, 0, 10, 0, 5, 0, 20, 0};    add_pair(v);
    v = '{0, 0, 10, 0, 11, 0, 20, 0};   add_pair(v);
    v = '{0, 0, 10, 0, 10, 0, 20, 0};   add_pair(v);
    v = '{5, 5, 5, 5, 5, 5, 5, 5};      add_pair(v);
    v = '{5, 5, 5, 5, 6, 5, 6, 5};      add_pair(v);
    v = '{3, 3, 3, 3, 0, 0, 6, 6};      add_pair(v);
    v = '{3, 4, 3, 4, 0, 0, 6, 6};      add_pair(v);
    v = '{0, 0, 4, 4, 5, 5, 0, 9};      add_pair(v);
    v = '{16'hfffd, 16'hffff, 16'h0007, 16'h0002, 16'hfffe, 16'h0005, 16'h0003,
          16'hfff9};
    add_pair(v);
    v = '{16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'h0, 16'h0, 16'h0, 16'h0};
    add_pair(v);
    v = '{16'h5555, 16'haaaa, 16'haaaa, 16'h5555, 16'h5555, 16'h5555, 16'haaaa,
          16'haaaa};
    add_pair(v);
    wait_drained();

    // random phases with different idling
    for (int ph = 0; ph < 4; ph++) begin
      send_idle = (ph == 1 || ph == 3) ? (ph == 1 ? 78 : 15) : 0;
      recv_idle = (ph == 2 || ph == 3) ? (ph == 2 ? 78 : 15) : 0;
      if (ph == 0) hold_off = 300;
      for (int i = 0; i < 310; i++) add_random();
      wait_drained();
    end
    send_idle = 0; recv_idle = 0;
    repeat (LATENCY + 20) @(posedge clk);
    $display("%0d words checked: %0d crossings, %0d overlaps, %0d apart", n_words,
             n_point, n_overlap, n_none);
    $display("covered extreme coordinates, touching, parallel, collinear and point cases");
    if (errors == 0 && meet_queue.size() == 0) begin
      $display("tb_segment_intersection: clean");
    end else begin
      $display("tb_segment_intersection: errors");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/si_pkg.sv
rtl/si_front.sv
rtl/si_queue.sv
rtl/si_back.sv
rtl/segment_intersection.sv
sim/tb_segment_intersection.sv
